// File: sv/pms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and register indexes of the prefetch mode selector.
// ----------------------------------------------------------------------------
package pms_pkg;

    // default sizes
    localparam int WINDOW_MAX_DEF = 64;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int LINE_SHIFT_DEF = 6;
    localparam int PAGE_SHIFT_DEF = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int RATIO_W    = 17;
    localparam int FRAC_W     = 16;

    // mode encoding
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_ORIG = 2'd1,
        MODE_FDP  = 2'd2,
        MODE_BOP  = 2'd3
    } pms_mode_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH   = 3'd0,
        CFG_EVAL_STRIDE     = 3'd1,
        CFG_DECISION_STREAK = 3'd2,
        CFG_LOCK_AFTER      = 3'd3,
        CFG_INITIAL_MODE    = 3'd4,
        CFG_BOP_PAGE_MIN    = 3'd5,
        CFG_FDP_PAGE_MAX    = 3'd6,
        CFG_ORIG_DELTA_MIN  = 3'd7
    } pms_cfg_idx_t;

    // register reset values
    localparam logic [6:0]         WINDOW_LENGTH_RST = 7'd32;
    localparam logic [15:0]        EVAL_STRIDE_RST   = 16'd1;
    localparam logic [7:0]         STREAK_RST        = 8'd2;
    localparam logic [RATIO_W-1:0] BOP_MIN_RST       = 17'd32768;
    localparam logic [RATIO_W-1:0] FDP_MAX_RST       = 17'd16384;
    localparam logic [RATIO_W-1:0] ORIG_MIN_RST      = 17'd32768;

    localparam logic [6:0] WINDOW_MIN   = 7'd8;
    localparam logic [7:0] STREAK_SAT   = 8'd255;
    localparam int         SMALL_DELTA  = 4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DECIDE
    } pms_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rotate;
        logic decide;
    } pms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic eval_start;
        logic last_step;
    } pms_status_t;

endpackage
`default_nettype wire

// File: sv/pms_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_in_if / pms_out_if
// Valid/ready channels carrying access items in and selection results out.
// ----------------------------------------------------------------------------
interface pms_in_if #(
    parameter int ADDR_BITS = pms_pkg::ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] access_address;
    logic                 demand_access;

    modport source (output valid, output access_address, output demand_access, input ready);
    modport sink   (input valid, input access_address, input demand_access, output ready);
endinterface

interface pms_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] cur_mode;
    logic       evaluated;
    logic [1:0] candidate_mode;
    logic       switched;
    logic       is_locked;

    modport source (output valid, output cur_mode, output evaluated,
                    output candidate_mode, output switched, output is_locked,
                    input ready);
    modport sink   (input valid, input cur_mode, input evaluated,
                    input candidate_mode, input switched, input is_locked,
                    output ready);
endinterface
`default_nettype wire

// File: sv/prefetch_mode_selector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefetch_mode_selector_core
// Picks the active prefetch mode from a sliding window of demand accesses.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one access item (address, demand flag); out_ch returns one
//   result item per access: active mode, evaluated, candidate, switched, lock.
//   Registers are to be written through cfg_we / cfg_index / cfg_data only
//   while idle; the user must see to it, the core does not enforce it.
//   An access that runs no evaluation gives its result in the cycle after
//   it is accepted. For an evaluating access the page and line shift lines
//   are rotated once around, one entry per cycle, with the head page entry
//   compared against the older entries inside the window; then a decide
//   step compares the ratios and updates the mode.
//   One item is in flight at a time.
// Stalls: the result stays in an output register until taken; the next item
//   is accepted in the same cycle the result leaves.
// Reset: registers return to their defaults, the window is empty and the
//   active mode is none.
// ----------------------------------------------------------------------------
module prefetch_mode_selector_core #(
    parameter int WINDOW_MAX = pms_pkg::WINDOW_MAX_DEF,
    parameter int ADDR_BITS  = pms_pkg::ADDR_BITS_DEF,
    parameter int LINE_SHIFT = pms_pkg::LINE_SHIFT_DEF,
    parameter int PAGE_SHIFT = pms_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pms_in_if.sink                              in_ch,
    pms_out_if.source                           out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pms_pkg::CFG_DATA_W-1:0] cfg_data
);

    pms_pkg::pms_cmd_t    cmd;
    pms_pkg::pms_status_t status;

    // sequencer
    pms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // window and decision datapath
    pms_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .ADDR_BITS  (ADDR_BITS),
        .LINE_SHIFT (LINE_SHIFT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .access_address (in_ch.access_address),
        .demand_access  (in_ch.demand_access),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .cur_mode       (out_ch.cur_mode),
        .evaluated      (out_ch.evaluated),
        .candidate_mode (out_ch.candidate_mode),
        .switched       (out_ch.switched),
        .is_locked      (out_ch.is_locked)
    );

endmodule
`default_nettype wire

// File: sv/pms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: accepts items, runs the window sweep and holds the result valid.
// ----------------------------------------------------------------------------
module pms_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pms_pkg::pms_cmd_t        cmd,
    input  wire pms_pkg::pms_status_t status
);

    pms_pkg::pms_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // state and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pms_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pms_pkg::ST_IDLE:
            begin
                if (accept && status.eval_start)
                    state_next = pms_pkg::ST_ROTATE;
            end
            pms_pkg::ST_ROTATE:
            begin
                if (status.last_step)
                    state_next = pms_pkg::ST_DECIDE;
            end
            pms_pkg::ST_DECIDE:
            begin
                state_next = pms_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pms_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            pms_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                cmd.load = accept;
                if (accept && !status.eval_start)
                    out_valid_next = 1'b1;
            end
            pms_pkg::ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
            end
            pms_pkg::ST_DECIDE:
            begin
                cmd.decide     = 1'b1;
                out_valid_next = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/pms_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_datapath
// Window shift lines, evaluation counters, ratio compare and mode state.
// ----------------------------------------------------------------------------
module pms_datapath #(
    parameter int WINDOW_MAX = pms_pkg::WINDOW_MAX_DEF,
    parameter int ADDR_BITS  = pms_pkg::ADDR_BITS_DEF,
    parameter int LINE_SHIFT = pms_pkg::LINE_SHIFT_DEF,
    parameter int PAGE_SHIFT = pms_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ADDR_BITS-1:0]              access_address,
    input  wire logic                              demand_access,
    input  wire logic                              cfg_we,
    input  wire logic [pms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire pms_pkg::pms_cmd_t                 cmd,
    output pms_pkg::pms_status_t                   status,
    output logic [1:0]                             cur_mode,
    output logic                                   evaluated,
    output logic [1:0]                             candidate_mode,
    output logic                                   switched,
    output logic                                   is_locked
);

    localparam int LINE_W = ADDR_BITS - LINE_SHIFT;
    localparam int PAGE_W = ADDR_BITS - PAGE_SHIFT;
    localparam int WW     = $clog2(WINDOW_MAX + 1);
    localparam int KW     = $clog2(WINDOW_MAX);
    localparam int EW     = (WW > 7) ? WW : 7;
    localparam int PW     = pms_pkg::RATIO_W + WW;

    // configuration registers
    logic [6:0]                   wlen_reg;
    logic [15:0]                  stride_reg;
    logic [7:0]                   need_reg;
    logic                         lock_reg;
    logic [pms_pkg::RATIO_W-1:0]  bop_min_reg;
    logic [pms_pkg::RATIO_W-1:0]  fdp_max_reg;
    logic [pms_pkg::RATIO_W-1:0]  orig_min_reg;

    // window shift lines, newest at position zero
    logic [LINE_W-1:0] line_sh_reg [WINDOW_MAX];
    logic [PAGE_W-1:0] page_sh_reg [WINDOW_MAX];

    logic [WW-1:0]  fill_reg;
    logic [15:0]    phase_reg;
    logic [1:0]     mode_reg;
    logic [1:0]     cand_reg;
    logic [7:0]     streak_reg;
    logic           frozen_reg;
    logic           eval_flag_reg;
    logic           switched_reg;
    logic [KW-1:0]  step_reg;
    logic [WW-1:0]  distinct_reg;
    logic [WW-1:0]  small_reg;

    logic [WW-1:0]  w_eff;
    logic [WW-1:0]  fill_inc;
    logic           win_full;
    logic [16:0]    phase_inc;
    logic [ADDR_BITS-1:0] addr;
    logic           page_seen;
    logic           page_new;
    logic           delta_small;
    logic [LINE_W-1:0] line_diff;
    logic           in_pages;
    logic           in_pairs;
    logic [PW-1:0]  page_lhs;
    logic [PW-1:0]  delta_lhs;
    logic [PW-1:0]  bop_prod;
    logic [PW-1:0]  fdp_prod;
    logic [PW-1:0]  orig_prod;
    logic [1:0]     cand;
    logic [7:0]     need;
    logic [7:0]     streak_new;
    logic           do_switch;

    assign addr = access_address;

    // clamped window length
    always_comb
    begin
        priority if (EW'(wlen_reg) < EW'(pms_pkg::WINDOW_MIN))
            w_eff = WW'(pms_pkg::WINDOW_MIN);
        else if (EW'(wlen_reg) > EW'(WINDOW_MAX))
            w_eff = WW'(WINDOW_MAX);
        else
            w_eff = WW'(wlen_reg);
    end

    // fill and stride phase for the incoming item
    assign fill_inc  = (fill_reg == WW'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
    assign win_full  = fill_inc >= w_eff;
    assign phase_inc = {1'b0, phase_reg} + 17'd1;

    assign status.eval_start = demand_access && win_full && (phase_reg == 16'd0) &&
                               !frozen_reg;
    assign status.last_step  = (step_reg == KW'(WINDOW_MAX - 1));

    // page match of the head entry against older entries in the window
    always_comb
    begin
        page_seen = 1'b0;
        for (int q = 1; q < WINDOW_MAX; q++)
        begin
            if ((page_sh_reg[q] == page_sh_reg[0]) &&
                ((EW + 1)'(step_reg) + (EW + 1)'(q) < (EW + 1)'(w_eff)))
                page_seen = 1'b1;
        end
    end

    assign in_pages = (EW + 1)'(step_reg) < (EW + 1)'(w_eff);
    assign in_pairs = (EW + 1)'(step_reg) + (EW + 1)'(1) < (EW + 1)'(w_eff);
    assign page_new = in_pages && !page_seen;

    // adjacent line delta
    assign line_diff   = (line_sh_reg[0] >= line_sh_reg[1]) ?
                         (line_sh_reg[0] - line_sh_reg[1]) :
                         (line_sh_reg[1] - line_sh_reg[0]);
    assign delta_small = in_pairs && (line_diff <= LINE_W'(pms_pkg::SMALL_DELTA));

    // ratio compares done as cross products against the thresholds
    assign page_lhs  = PW'({distinct_reg, {pms_pkg::FRAC_W{1'b0}}});
    assign delta_lhs = PW'({small_reg, {pms_pkg::FRAC_W{1'b0}}});
    assign bop_prod  = PW'(bop_min_reg) * PW'(w_eff);
    assign fdp_prod  = PW'(fdp_max_reg) * PW'(w_eff);
    assign orig_prod = PW'(orig_min_reg) * PW'(w_eff - 1'b1);

    always_comb
    begin
        priority if (page_lhs >= bop_prod)
            cand = pms_pkg::MODE_BOP;
        else if (delta_lhs >= orig_prod)
            cand = pms_pkg::MODE_ORIG;
        else if (page_lhs < fdp_prod)
            cand = pms_pkg::MODE_FDP;
        else
            cand = pms_pkg::MODE_ORIG;
    end

    // streak and switch decision
    assign need       = (need_reg == 8'd0) ? 8'd1 : need_reg;
    assign streak_new = (cand != cand_reg) ? 8'd1 :
                        (streak_reg == pms_pkg::STREAK_SAT) ? streak_reg : streak_reg + 8'd1;
    assign do_switch  = (streak_new >= need) && (cand != mode_reg);

    // window shift lines: shift in on a demand item, rotate during the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.load && demand_access)
        begin
            line_sh_reg[0] <= addr[ADDR_BITS-1:LINE_SHIFT];
            page_sh_reg[0] <= addr[ADDR_BITS-1:PAGE_SHIFT];
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                line_sh_reg[i] <= line_sh_reg[i-1];
                page_sh_reg[i] <= page_sh_reg[i-1];
            end
        end
        else if (cmd.rotate)
        begin
            line_sh_reg[WINDOW_MAX-1] <= line_sh_reg[0];
            page_sh_reg[WINDOW_MAX-1] <= page_sh_reg[0];
            for (int i = 0; i < WINDOW_MAX - 1; i++)
            begin
                line_sh_reg[i] <= line_sh_reg[i+1];
                page_sh_reg[i] <= page_sh_reg[i+1];
            end
        end
    end

    // control and mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= pms_pkg::WINDOW_LENGTH_RST;
            stride_reg    <= pms_pkg::EVAL_STRIDE_RST;
            need_reg      <= pms_pkg::STREAK_RST;
            lock_reg      <= 1'b0;
            bop_min_reg   <= pms_pkg::BOP_MIN_RST;
            fdp_max_reg   <= pms_pkg::FDP_MAX_RST;
            orig_min_reg  <= pms_pkg::ORIG_MIN_RST;
            fill_reg      <= '0;
            phase_reg     <= '0;
            mode_reg      <= pms_pkg::MODE_NONE;
            cand_reg      <= pms_pkg::MODE_NONE;
            streak_reg    <= '0;
            frozen_reg    <= 1'b0;
            eval_flag_reg <= 1'b0;
            switched_reg  <= 1'b0;
            step_reg      <= '0;
            distinct_reg  <= '0;
            small_reg     <= '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (pms_pkg::pms_cfg_idx_t'(cfg_index))
                    pms_pkg::CFG_WINDOW_LENGTH:   wlen_reg     <= cfg_data[6:0];
                    pms_pkg::CFG_EVAL_STRIDE:     stride_reg   <= cfg_data[15:0];
                    pms_pkg::CFG_DECISION_STREAK: need_reg     <= cfg_data[7:0];
                    pms_pkg::CFG_LOCK_AFTER:      lock_reg     <= cfg_data[0];
                    pms_pkg::CFG_INITIAL_MODE:    mode_reg     <= cfg_data[1:0];
                    pms_pkg::CFG_BOP_PAGE_MIN:    bop_min_reg  <= cfg_data;
                    pms_pkg::CFG_FDP_PAGE_MAX:    fdp_max_reg  <= cfg_data;
                    pms_pkg::CFG_ORIG_DELTA_MIN:  orig_min_reg <= cfg_data;
                    default:                      lock_reg     <= lock_reg;
                endcase
            end

            // item accepted
            if (cmd.load)
            begin
                eval_flag_reg <= 1'b0;
                switched_reg  <= 1'b0;
                step_reg      <= '0;
                distinct_reg  <= '0;
                small_reg     <= '0;
                if (demand_access)
                begin
                    fill_reg <= fill_inc;
                    if (!win_full)
                        phase_reg <= '0;
                    else if (phase_inc >= {1'b0, stride_reg})
                        phase_reg <= '0;
                    else
                        phase_reg <= phase_inc[15:0];
                end
            end

            // window sweep
            if (cmd.rotate)
            begin
                step_reg     <= step_reg + 1'b1;
                distinct_reg <= distinct_reg + WW'(page_new);
                small_reg    <= small_reg + WW'(delta_small);
            end

            // classification result
            if (cmd.decide)
            begin
                eval_flag_reg <= 1'b1;
                cand_reg      <= cand;
                streak_reg    <= streak_new;
                if (do_switch)
                begin
                    mode_reg     <= cand;
                    switched_reg <= 1'b1;
                    if (lock_reg && (cand != pms_pkg::MODE_NONE))
                        frozen_reg <= 1'b1;
                end
            end
        end
    end

    assign cur_mode       = mode_reg;
    assign evaluated      = eval_flag_reg;
    assign candidate_mode = cand_reg;
    assign switched       = switched_reg;
    assign is_locked      = frozen_reg;

endmodule
`default_nettype wire
